[src/dsd_pkg.sv]
// shared types and constants for the dual servo slew-to-duty block
`timescale 1ns / 1ps

package dsd_pkg;

   localparam int ANGLE_W = 8;
   localparam int PULSE_W = 12;
   localparam int DUTY_W = 11;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam int ANGLE_SPAN_DEFAULT = 180;
   localparam logic [ANGLE_W-1:0] POSITION_RESET = 8'd90;
   localparam logic [PULSE_W-1:0] MIN_PULSE_RESET = 12'd500;
   localparam logic [PULSE_W-1:0] MAX_PULSE_RESET = 12'd2500;

   // duty = pulse * 8192 / 20000 = (pulse << 8) / 625
   localparam int DUTY_SHIFT = 8;
   localparam int DIV_SHIFT = 20;
   localparam int MUL_B_W = 14;
   localparam int PROD_W = DIV_SHIFT + MUL_B_W;
   localparam logic [MUL_B_W-1:0] PERIOD_DIV = 14'd625;
   localparam logic [MUL_B_W-1:0] RECIP_PERIOD = MUL_B_W'((1 << DIV_SHIFT) / 625);
   localparam logic [DUTY_W-1:0] DUTY_MAX = 11'd1677;

   localparam logic CSR_MIN_PULSE = 1'b0;
   localparam logic CSR_MAX_PULSE = 1'b1;

   typedef enum logic [3:0] {
      OP_NONE  = 4'd0,
      OP_SLEW  = 4'd1,
      OP_SCALE = 4'd2,
      OP_RECIP = 4'd3,
      OP_BACK  = 4'd4,
      OP_ROUND = 4'd5,
      OP_PULSE = 4'd6,
      OP_STORE = 4'd7,
      OP_EMIT  = 4'd8
   } op_type;

   typedef struct packed {
      op_type op;
      logic   servo;
      logic   phase;
   } cmd_type;

endpackage

[src/dsd_ctrl.sv]
// sequencer that steps the shared multiplier through both servo mappings
`timescale 1ns / 1ps

module dsd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output dsd_pkg::cmd_type cmd
);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_SCALE = 9'b000000010,
      ST_RECIP = 9'b000000100,
      ST_BACK  = 9'b000001000,
      ST_ROUND = 9'b000010000,
      ST_PULSE = 9'b000100000,
      ST_STORE = 9'b001000000,
      ST_EMIT  = 9'b010000000,
      ST_SPARE = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic servo_ff, servo_in;
   logic phase_ff, phase_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      servo_in = servo_ff;
      phase_in = phase_ff;
      req_ready = 1'b0;
      cmd.op = dsd_pkg::OP_NONE;
      cmd.servo = servo_ff;
      cmd.phase = phase_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = dsd_pkg::OP_SLEW;
               servo_in = 1'b0;
               phase_in = 1'b0;
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.op = dsd_pkg::OP_SCALE;
            phase_in = 1'b0;
            state_in = ST_RECIP;
         end
         ST_RECIP: begin
            cmd.op = dsd_pkg::OP_RECIP;
            state_in = ST_BACK;
         end
         ST_BACK: begin
            cmd.op = dsd_pkg::OP_BACK;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.op = dsd_pkg::OP_ROUND;
            state_in = phase_ff ? ST_STORE : ST_PULSE;
         end
         ST_PULSE: begin
            cmd.op = dsd_pkg::OP_PULSE;
            phase_in = 1'b1;
            state_in = ST_RECIP;
         end
         ST_STORE: begin
            cmd.op = dsd_pkg::OP_STORE;
            if (servo_ff) begin
               state_in = ST_EMIT;
            end else begin
               servo_in = 1'b1;
               state_in = ST_SCALE;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op = dsd_pkg::OP_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = (cmd.op == dsd_pkg::OP_EMIT) || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         servo_ff <= 1'b0;
         phase_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         servo_ff <= servo_in;
         phase_ff <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[src/dsd_datapath.sv]
// positions, shared multiplier with reciprocal division, and result registers
`timescale 1ns / 1ps

module dsd_datapath #(
   parameter int ANGLE_SPAN = dsd_pkg::ANGLE_SPAN_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  dsd_pkg::cmd_type                cmd,
   input  logic [dsd_pkg::ANGLE_W-1:0]     req_target_one,
   input  logic [dsd_pkg::ANGLE_W-1:0]     req_target_two,
   input  logic [dsd_pkg::PULSE_W-1:0]     min_pulse_us,
   input  logic [dsd_pkg::PULSE_W-1:0]     max_pulse_us,
   output logic [dsd_pkg::ANGLE_W-1:0]     rsp_angle_one,
   output logic [dsd_pkg::ANGLE_W-1:0]     rsp_angle_two,
   output logic [dsd_pkg::DUTY_W-1:0]      rsp_duty_one,
   output logic [dsd_pkg::DUTY_W-1:0]      rsp_duty_two,
   output logic                            rsp_settled
);

   localparam int AW = dsd_pkg::ANGLE_W;
   localparam int PW = dsd_pkg::PULSE_W;
   localparam int DW = dsd_pkg::DUTY_W;
   localparam int XW = dsd_pkg::DIV_SHIFT;
   localparam int BW = dsd_pkg::MUL_B_W;
   localparam int RW = dsd_pkg::PROD_W;
   localparam logic [AW-1:0] SpanAngle = AW'(ANGLE_SPAN);
   localparam logic [BW-1:0] RecipSpan = BW'((1 << dsd_pkg::DIV_SHIFT) / ANGLE_SPAN);

   logic [AW-1:0] pos_one_ff, pos_one_in;
   logic [AW-1:0] pos_two_ff, pos_two_in;
   logic [AW-1:0] tgt_one_ff, tgt_two_ff;
   logic [AW-1:0] sat_one, sat_two;
   logic [RW-1:0] prod_ff, prod_in;
   logic [XW-1:0] x_ff;
   logic [BW-1:0] q_ff;
   logic [DW-1:0] duty_one_ff, duty_two_ff;
   logic [AW-1:0] rsp_angle_one_ff, rsp_angle_two_ff;
   logic [DW-1:0] rsp_duty_one_ff, rsp_duty_two_ff;
   logic          rsp_settled_ff;

   logic [AW-1:0] angle_sel;
   logic          up_dir;
   logic [PW-1:0] span;
   logic [PW-1:0] pulse;
   logic [BW-1:0] divisor;
   logic [BW-1:0] recip;
   logic [XW-1:0] mul_a;
   logic [BW-1:0] mul_b;
   logic [RW-1:0] mul_p;
   logic [XW-1:0] rem;
   logic          rem_over;

   function automatic logic [AW-1:0] slew(input logic [AW-1:0] cur, input logic [AW-1:0] tgt);
      logic [AW-1:0] nxt;
      nxt = cur;
      if (tgt > cur) nxt = cur + 1'b1;
      else if (tgt < cur) nxt = cur - 1'b1;
      return nxt;
   endfunction

   assign sat_one = (req_target_one > SpanAngle) ? SpanAngle : req_target_one;
   assign sat_two = (req_target_two > SpanAngle) ? SpanAngle : req_target_two;
   assign pos_one_in = slew(pos_one_ff, sat_one);
   assign pos_two_in = slew(pos_two_ff, sat_two);

   assign angle_sel = cmd.servo ? pos_two_ff : pos_one_ff;
   assign up_dir = (max_pulse_us >= min_pulse_us);
   assign span = up_dir ? (max_pulse_us - min_pulse_us) : (min_pulse_us - max_pulse_us);
   assign divisor = cmd.phase ? dsd_pkg::PERIOD_DIV : BW'(SpanAngle);
   assign recip = cmd.phase ? dsd_pkg::RECIP_PERIOD : RecipSpan;
   assign pulse = up_dir ? (min_pulse_us + q_ff[PW-1:0]) : (min_pulse_us - q_ff[PW-1:0]);
   assign rem = x_ff - prod_ff[XW-1:0];
   assign rem_over = (rem >= XW'(divisor));

   always_comb begin
      case (cmd.op)
         dsd_pkg::OP_SCALE: begin
            mul_a = XW'(span);
            mul_b = BW'(angle_sel);
         end
         dsd_pkg::OP_RECIP: begin
            mul_a = prod_ff[XW-1:0];
            mul_b = recip;
         end
         dsd_pkg::OP_BACK: begin
            mul_a = XW'(prod_ff[RW-1:XW]);
            mul_b = divisor;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = RW'(mul_a) * RW'(mul_b);

   always_comb begin
      case (cmd.op)
         dsd_pkg::OP_SCALE, dsd_pkg::OP_RECIP, dsd_pkg::OP_BACK: begin
            prod_in = mul_p;
         end
         dsd_pkg::OP_PULSE: begin
            prod_in = RW'({pulse, {dsd_pkg::DUTY_SHIFT{1'b0}}});
         end
         default: begin
            prod_in = prod_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_one_ff <= dsd_pkg::POSITION_RESET;
         pos_two_ff <= dsd_pkg::POSITION_RESET;
      end else if (cmd.op == dsd_pkg::OP_SLEW) begin
         pos_one_ff <= pos_one_in;
         pos_two_ff <= pos_two_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      case (cmd.op)
         dsd_pkg::OP_SLEW: begin
            tgt_one_ff <= sat_one;
            tgt_two_ff <= sat_two;
         end
         dsd_pkg::OP_RECIP: begin
            x_ff <= prod_ff[XW-1:0];
         end
         dsd_pkg::OP_BACK: begin
            q_ff <= prod_ff[RW-1:XW];
         end
         dsd_pkg::OP_ROUND: begin
            q_ff <= q_ff + BW'(rem_over);
         end
         dsd_pkg::OP_STORE: begin
            if (cmd.servo) duty_two_ff <= q_ff[DW-1:0];
            else duty_one_ff <= q_ff[DW-1:0];
         end
         dsd_pkg::OP_EMIT: begin
            rsp_angle_one_ff <= pos_one_ff;
            rsp_angle_two_ff <= pos_two_ff;
            rsp_duty_one_ff <= duty_one_ff;
            rsp_duty_two_ff <= duty_two_ff;
            rsp_settled_ff <= (pos_one_ff == tgt_one_ff) && (pos_two_ff == tgt_two_ff);
         end
         default: begin
         end
      endcase
   end

   assign rsp_angle_one = rsp_angle_one_ff;
   assign rsp_angle_two = rsp_angle_two_ff;
   assign rsp_duty_one = rsp_duty_one_ff;
   assign rsp_duty_two = rsp_duty_two_ff;
   assign rsp_settled = rsp_settled_ff;

endmodule

[src/dual_servo_slew_to_duty.sv]
// Dual servo slew limiter: each accepted beat carries two target angles
// (saturated to ANGLE_SPAN); both held angles move one degree toward their
// targets, then each angle is mapped linearly between the min and max pulse
// widths and scaled to an 11-bit PWM duty count for a 20 ms period. One
// result beat per request beat. The block takes one request at a time: its
// result is registered once both servos are mapped, and the next request
// can be taken in the cycle that result is first shown. The single shared
// 20x14 multiplier forms five products per servo (scale, reciprocal and
// back-multiply for the angle division, then reciprocal and back-multiply
// for the duty division). The result sits in an output register, so a
// stalled consumer holds off only the following item. Pulse limits must be
// written over the APB port while no request is in flight (not enforced).
`timescale 1ns / 1ps

module dual_servo_slew_to_duty #(
   parameter int ANGLE_SPAN = dsd_pkg::ANGLE_SPAN_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [dsd_pkg::ANGLE_W-1:0]       req_target_one,
   input  logic [dsd_pkg::ANGLE_W-1:0]       req_target_two,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [dsd_pkg::ANGLE_W-1:0]       rsp_angle_one,
   output logic [dsd_pkg::ANGLE_W-1:0]       rsp_angle_two,
   output logic [dsd_pkg::DUTY_W-1:0]        rsp_duty_one,
   output logic [dsd_pkg::DUTY_W-1:0]        rsp_duty_two,
   output logic                              rsp_settled,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [dsd_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [dsd_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [dsd_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   logic [dsd_pkg::PULSE_W-1:0] min_pulse_ff, min_pulse_in;
   logic [dsd_pkg::PULSE_W-1:0] max_pulse_ff, max_pulse_in;
   logic csr_write;
   logic csr_index;
   dsd_pkg::cmd_type cmd;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index = csr_paddr[2];

   always_comb begin
      min_pulse_in = min_pulse_ff;
      max_pulse_in = max_pulse_ff;
      if (csr_write) begin
         case (csr_index)
            dsd_pkg::CSR_MIN_PULSE: min_pulse_in = csr_pwdata[dsd_pkg::PULSE_W-1:0];
            dsd_pkg::CSR_MAX_PULSE: max_pulse_in = csr_pwdata[dsd_pkg::PULSE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         dsd_pkg::CSR_MIN_PULSE: csr_prdata = dsd_pkg::CSR_DATA_W'(min_pulse_ff);
         dsd_pkg::CSR_MAX_PULSE: csr_prdata = dsd_pkg::CSR_DATA_W'(max_pulse_ff);
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_pulse_ff <= dsd_pkg::MIN_PULSE_RESET;
         max_pulse_ff <= dsd_pkg::MAX_PULSE_RESET;
      end else begin
         min_pulse_ff <= min_pulse_in;
         max_pulse_ff <= max_pulse_in;
      end
   end

   dsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   dsd_datapath #(
      .ANGLE_SPAN (ANGLE_SPAN)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_target_one (req_target_one),
      .req_target_two (req_target_two),
      .min_pulse_us   (min_pulse_ff),
      .max_pulse_us   (max_pulse_ff),
      .rsp_angle_one  (rsp_angle_one),
      .rsp_angle_two  (rsp_angle_two),
      .rsp_duty_one   (rsp_duty_one),
      .rsp_duty_two   (rsp_duty_two),
      .rsp_settled    (rsp_settled)
   );

endmodule

[src/dsd_checker.sv]
// port-level checks for the dual servo slew-to-duty block, bound to the top level
`timescale 1ns / 1ps

module dsd_checker #(
   parameter int ANGLE_SPAN = dsd_pkg::ANGLE_SPAN_DEFAULT
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [dsd_pkg::ANGLE_W-1:0]       rsp_angle_one,
   input logic [dsd_pkg::ANGLE_W-1:0]       rsp_angle_two,
   input logic [dsd_pkg::DUTY_W-1:0]        rsp_duty_one,
   input logic [dsd_pkg::DUTY_W-1:0]        rsp_duty_two,
   input logic                              rsp_settled
);

   localparam logic [dsd_pkg::ANGLE_W-1:0] SpanAngle = dsd_pkg::ANGLE_W'(ANGLE_SPAN);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_angle_one)
         && $stable(rsp_angle_two) && $stable(rsp_duty_one)
         && $stable(rsp_duty_two) && $stable(rsp_settled))
      else $error("result beat changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous beat still in work");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_angle_one <= SpanAngle && rsp_angle_two <= SpanAngle)
      else $error("result angle beyond span");

   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_duty_one <= dsd_pkg::DUTY_MAX && rsp_duty_two <= dsd_pkg::DUTY_MAX)
      else $error("duty count beyond largest pulse");

endmodule

bind dual_servo_slew_to_duty dsd_checker #(.ANGLE_SPAN(ANGLE_SPAN)) u_dsd_checker (.*);
